[sv/slc_pkg.sv]
// ----------------------------------------------------------------------------
// slc_pkg
// Shared types, sizes and tables of the stacked softmax classifier.
// ----------------------------------------------------------------------------
package slc_pkg;

   localparam int NUM_CLASSES          = 8;
   localparam int NUM_CHANNELS         = 3;
   localparam int PER_CHANNEL_FEATURES = 20;
   localparam int CROSS_FEATURES       = 9;
   localparam int WEIGHT_DEPTH         = 1024;
   localparam int TD_PER_CH            = 12;
   localparam int FD_PER_CH            = 8;
   localparam int NUM_FEATURES   = NUM_CHANNELS * PER_CHANNEL_FEATURES + CROSS_FEATURES;
   localparam int CC_OFFSET      = NUM_CHANNELS * PER_CHANNEL_FEATURES;
   localparam int TD_LEN         = TD_PER_CH * NUM_CHANNELS;
   localparam int FD_LEN         = FD_PER_CH * NUM_CHANNELS;
   localparam int META_LEN       = 3 * NUM_CLASSES;
   localparam int ICPT_DEPTH     = 4 * NUM_CLASSES;
   localparam int CLS_W          = $clog2(NUM_CLASSES);
   localparam int FEAT_AW        = $clog2(NUM_FEATURES);
   localparam int WGT_AW         = $clog2(WEIGHT_DEPTH);
   localparam int ICPT_AW        = $clog2(ICPT_DEPTH);
   localparam int SPEC_AW        = $clog2(META_LEN);
   localparam int EXP_BITS       = 20;

   typedef enum logic [1:0] {
      OP_WRITE_FEATURE   = 2'd0,
      OP_WRITE_WEIGHT    = 2'd1,
      OP_WRITE_INTERCEPT = 2'd2,
      OP_START           = 2'd3
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLASS,
      ST_ISSUE,
      ST_DRAIN,
      ST_SCORE,
      ST_MAX,
      ST_EXP_INIT,
      ST_EXP,
      ST_EXP_DONE,
      ST_DIV_INIT,
      ST_DIV,
      ST_PUT
   } state_type;

   localparam logic [31:0] EXP_TABLE [EXP_BITS] = '{
      32'd4294901760, 32'd4294836226, 32'd4294705160, 32'd4294443040, 32'd4293918848,
      32'd4292870656, 32'd4290775039, 32'd4286586875, 32'd4278222805, 32'd4261543595,
      32'd4228380000, 32'd4162825044, 32'd4034748382, 32'd3790295335, 32'd3344923893,
      32'd2605029347, 32'd1580030169, 32'd581260615,  32'd78665070,   32'd1440801
   };

   function automatic logic [5:0] stage_len(input logic [1:0] s);
      logic [5:0] len;
      unique case (s)
         2'd0:    len = 6'(TD_LEN);
         2'd1:    len = 6'(FD_LEN);
         2'd2:    len = 6'(CROSS_FEATURES);
         default: len = 6'(META_LEN);
      endcase
      return len;
   endfunction

   function automatic logic [FEAT_AW-1:0] stage_first(input logic [1:0] s);
      logic [FEAT_AW-1:0] fa;
      unique case (s)
         2'd0:    fa = '0;
         2'd1:    fa = FEAT_AW'(TD_PER_CH);
         2'd2:    fa = FEAT_AW'(CC_OFFSET);
         default: fa = '0;
      endcase
      return fa;
   endfunction

endpackage

[sv/slc_req_if.sv]
// ----------------------------------------------------------------------------
// slc_req_if / slc_rsp_if
// Valid/ready channels for load and start requests and for class results.
// ----------------------------------------------------------------------------
interface slc_req_if;
   logic                valid;
   logic                ready;
   logic [1:0]          operation;
   logic [9:0]          address;
   logic signed [31:0]  value;
   modport source (output valid, operation, address, value, input ready);
   modport sink   (input valid, operation, address, value, output ready);
endinterface

interface slc_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  class_index;
   logic [16:0] probability;
   logic        last;
   modport source (output valid, class_index, probability, last, input ready);
   modport sink   (input valid, class_index, probability, last, output ready);
endinterface

[sv/stacked_lda_softmax_classifier.sv]
// ----------------------------------------------------------------------------
// stacked_lda_softmax_classifier
// Three specialist linear scorers with softmax feed a meta scorer.
// ----------------------------------------------------------------------------
// channel | dir | payload                                | per transaction
// req     | in  | operation, address, value              | load or start
// rsp     | out | class_index, probability, last         | one class result
//
// A start walks 744 weight words one per cycle through the weight memory
// read port and a 32x32 multiplier, plus per class a setup and a drain,
// then per stage a max search, and per class an exponential and a division
// with output. Results leave through an output register; a stalled result
// holds the divider. Reset is synchronous and clears control only; stores
// are undefined until written.
// ----------------------------------------------------------------------------
module stacked_lda_softmax_classifier (
   input  logic        clock,
   input  logic        reset,
   slc_req_if.sink     req,
   slc_rsp_if.source   rsp
);

   localparam int CW = slc_pkg::CLS_W;
   localparam int ICPT_AW_L = slc_pkg::ICPT_AW;

   // memories
   logic signed [31:0] feat_mem [slc_pkg::NUM_FEATURES];
   logic signed [31:0] wgt_mem  [slc_pkg::WEIGHT_DEPTH];
   logic signed [31:0] icpt_mem [slc_pkg::ICPT_DEPTH];
   logic [16:0]        spec_mem [slc_pkg::META_LEN];
   logic signed [31:0] feat_q, wgt_q, icpt_q;
   logic [16:0]        spec_q;

   slc_pkg::state_type state_ff, state_in;

   logic [1:0]                 stage_ff;
   logic [CW-1:0]              cls_ff;
   logic [5:0]                 term_ff;
   logic [3:0]                 k_ff;
   logic [slc_pkg::FEAT_AW-1:0] fa_ff;
   logic [slc_pkg::WGT_AW-1:0]  wa_ff;
   logic                       v1_ff, v2_ff;
   logic signed [63:0]         prod_ff;
   logic signed [55:0]         acc_ff;
   logic signed [31:0]         score_ff [slc_pkg::NUM_CLASSES];
   logic signed [31:0]         max_ff;
   logic [32:0]                d_ff;
   logic [32:0]                r_ff;
   logic [16:0]                e_ff [slc_pkg::NUM_CLASSES];
   logic [19:0]                sum_ff;
   logic [5:0]                 step_ff;
   logic [34:0]                num_ff;
   logic [20:0]                rem_ff;
   logic [16:0]                quo_ff;
   logic                       rsp_valid_ff;
   logic [2:0]                 rsp_class_ff;
   logic [16:0]                rsp_prob_ff;
   logic                       rsp_last_ff;

   logic               accept, issue, cls_last, term_last, put_go;
   logic [1:0]         k_wrap_sel;
   logic signed [31:0] x_s;
   logic signed [55:0] total;
   logic signed [31:0] sat;
   logic [64:0]        rp;
   logic [20:0]        trial;
   logic [ICPT_AW_L-1:0] icpt_addr;

   assign accept    = req.valid && req.ready;
   assign issue     = (state_ff == slc_pkg::ST_ISSUE);
   assign cls_last  = (cls_ff == CW'(slc_pkg::NUM_CLASSES - 1));
   assign term_last = (term_ff == slc_pkg::stage_len(stage_ff) - 6'd1);
   assign put_go    = (stage_ff != 2'd3) || !rsp_valid_ff || rsp.ready;
   assign k_wrap_sel = stage_ff;
   assign icpt_addr = {stage_ff, cls_ff};

   // memory ports
   always_ff @(posedge clock) begin
      if (accept && req.operation == slc_pkg::OP_WRITE_FEATURE
          && 32'(req.address) < 32'(slc_pkg::NUM_FEATURES)) begin
         feat_mem[req.address[slc_pkg::FEAT_AW-1:0]] <= req.value;
      end
      feat_q <= feat_mem[fa_ff];
   end

   always_ff @(posedge clock) begin
      if (accept && req.operation == slc_pkg::OP_WRITE_WEIGHT) begin
         wgt_mem[req.address[slc_pkg::WGT_AW-1:0]] <= req.value;
      end
      wgt_q <= wgt_mem[wa_ff];
   end

   always_ff @(posedge clock) begin
      if (accept && req.operation == slc_pkg::OP_WRITE_INTERCEPT
          && 32'(req.address) < 32'(slc_pkg::ICPT_DEPTH)) begin
         icpt_mem[req.address[ICPT_AW_L-1:0]] <= req.value;
      end
      if (state_ff == slc_pkg::ST_CLASS) begin
         icpt_q <= icpt_mem[icpt_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == slc_pkg::ST_PUT && put_go && stage_ff != 2'd3) begin
         spec_mem[{stage_ff[1:0], cls_ff}] <= quo_ff;
      end
      spec_q <= spec_mem[fa_ff[slc_pkg::SPEC_AW-1:0]];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         slc_pkg::ST_IDLE:
            if (accept && req.operation == slc_pkg::OP_START) state_in = slc_pkg::ST_CLASS;
         slc_pkg::ST_CLASS:    state_in = slc_pkg::ST_ISSUE;
         slc_pkg::ST_ISSUE:    if (term_last) state_in = slc_pkg::ST_DRAIN;
         slc_pkg::ST_DRAIN:    if (!v1_ff && !v2_ff) state_in = slc_pkg::ST_SCORE;
         slc_pkg::ST_SCORE:
            state_in = cls_last ? slc_pkg::ST_MAX : slc_pkg::ST_CLASS;
         slc_pkg::ST_MAX:      if (cls_last) state_in = slc_pkg::ST_EXP_INIT;
         slc_pkg::ST_EXP_INIT: state_in = slc_pkg::ST_EXP;
         slc_pkg::ST_EXP:
            if (step_ff == 6'(slc_pkg::EXP_BITS - 1)) state_in = slc_pkg::ST_EXP_DONE;
         slc_pkg::ST_EXP_DONE:
            state_in = cls_last ? slc_pkg::ST_DIV_INIT : slc_pkg::ST_EXP_INIT;
         slc_pkg::ST_DIV_INIT: state_in = slc_pkg::ST_DIV;
         slc_pkg::ST_DIV:      if (step_ff == 6'd34) state_in = slc_pkg::ST_PUT;
         slc_pkg::ST_PUT: begin
            if (put_go) begin
               if (!cls_last)            state_in = slc_pkg::ST_DIV_INIT;
               else if (stage_ff == 2'd3) state_in = slc_pkg::ST_IDLE;
               else                      state_in = slc_pkg::ST_CLASS;
            end
         end
         default: state_in = slc_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req.ready       = (state_ff == slc_pkg::ST_IDLE);
      rsp.valid       = rsp_valid_ff;
      rsp.class_index = rsp_class_ff;
      rsp.probability = rsp_prob_ff;
      rsp.last        = rsp_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= slc_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
      end else begin
         state_ff <= state_in;
         v1_ff    <= issue;
         v2_ff    <= v1_ff;
         if (state_ff == slc_pkg::ST_PUT && put_go && stage_ff == 2'd3) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath
   always_comb begin
      x_s   = (stage_ff == 2'd3) ? $signed({15'd0, spec_q}) : feat_q;
      total = acc_ff + {{24{icpt_q[31]}}, icpt_q};
      if (total > 56'sd2147483647)        sat = 32'sh7FFFFFFF;
      else if (total < -56'sd2147483648)  sat = 32'sh80000000;
      else                                sat = total[31:0];
      rp    = 65'(r_ff) * 65'(slc_pkg::EXP_TABLE[step_ff[4:0]]);
      trial = {rem_ff[19:0], num_ff[34]};
   end

   always_ff @(posedge clock) begin
      if (v1_ff) prod_ff <= x_s * wgt_q;
      if (v2_ff) acc_ff  <= acc_ff + 56'(prod_ff >>> 16);
      unique case (state_ff)
         slc_pkg::ST_IDLE: begin
            stage_ff <= 2'd0;
            cls_ff   <= '0;
            wa_ff    <= '0;
         end
         slc_pkg::ST_CLASS: begin
            term_ff <= '0;
            k_ff    <= '0;
            fa_ff   <= slc_pkg::stage_first(stage_ff);
            acc_ff  <= '0;
         end
         slc_pkg::ST_ISSUE: begin
            term_ff <= term_ff + 6'd1;
            wa_ff   <= wa_ff + 1'b1;
            // step to the next channel block at the end of a slice
            if (k_wrap_sel == 2'd0 && k_ff == 4'(slc_pkg::TD_PER_CH - 1)) begin
               k_ff  <= '0;
               fa_ff <= fa_ff + slc_pkg::FEAT_AW'(slc_pkg::PER_CHANNEL_FEATURES
                                                  - slc_pkg::TD_PER_CH + 1);
            end else if (k_wrap_sel == 2'd1 && k_ff == 4'(slc_pkg::FD_PER_CH - 1)) begin
               k_ff  <= '0;
               fa_ff <= fa_ff + slc_pkg::FEAT_AW'(slc_pkg::PER_CHANNEL_FEATURES
                                                  - slc_pkg::FD_PER_CH + 1);
            end else begin
               k_ff  <= k_ff + 4'd1;
               fa_ff <= fa_ff + 1'b1;
            end
         end
         slc_pkg::ST_SCORE: begin
            score_ff[cls_ff] <= sat;
            cls_ff <= cls_ff + 1'b1;
         end
         slc_pkg::ST_MAX: begin
            if (cls_ff == '0 || score_ff[cls_ff] > max_ff) max_ff <= score_ff[cls_ff];
            cls_ff <= cls_ff + 1'b1;
            sum_ff <= '0;
         end
         slc_pkg::ST_EXP_INIT: begin
            d_ff    <= 33'({max_ff[31], max_ff} - {score_ff[cls_ff][31], score_ff[cls_ff]});
            r_ff    <= 33'h1_0000_0000;
            step_ff <= '0;
         end
         slc_pkg::ST_EXP: begin
            if (d_ff[step_ff[4:0]]) r_ff <= 33'((rp + 65'h8000_0000) >> 32);
            step_ff <= step_ff + 6'd1;
         end
         slc_pkg::ST_EXP_DONE: begin
            // no contribution once the gap reaches sixteen
            if (|d_ff[32:slc_pkg::EXP_BITS]) begin
               e_ff[cls_ff] <= '0;
            end else begin
               e_ff[cls_ff] <= 17'((r_ff + 33'h8000) >> 16);
               sum_ff <= sum_ff + 20'(17'((r_ff + 33'h8000) >> 16));
            end
            cls_ff <= cls_ff + 1'b1;
         end
         slc_pkg::ST_DIV_INIT: begin
            num_ff  <= 35'({e_ff[cls_ff], 16'd0}) + 35'(sum_ff >> 1);
            rem_ff  <= '0;
            quo_ff  <= '0;
            step_ff <= '0;
         end
         slc_pkg::ST_DIV: begin
            if (trial >= {1'b0, sum_ff}) begin
               rem_ff <= trial - {1'b0, sum_ff};
               quo_ff <= {quo_ff[15:0], 1'b1};
            end else begin
               rem_ff <= trial;
               quo_ff <= {quo_ff[15:0], 1'b0};
            end
            num_ff  <= {num_ff[33:0], 1'b0};
            step_ff <= step_ff + 6'd1;
         end
         slc_pkg::ST_PUT: begin
            if (put_go) begin
               // only the meta stage reaches the output register
               if (stage_ff == 2'd3) begin
                  rsp_class_ff <= 3'(cls_ff);
                  rsp_prob_ff  <= quo_ff;
                  rsp_last_ff  <= cls_last;
               end
               cls_ff       <= cls_ff + 1'b1;
               if (cls_last) stage_ff <= stage_ff + 2'd1;
            end
         end
         default: ;
      endcase
   end

endmodule

[sv/slc_checker.sv]
// ----------------------------------------------------------------------------
// slc_checker
// Port-level checks of the classifier, bound to the top level.
// ----------------------------------------------------------------------------
module slc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [1:0]  req_operation,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_class_index,
   input logic [16:0] rsp_probability,
   input logic        rsp_last
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_probability))
      else $error("rsp transaction dropped while stalled");

   a_last_class: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_class_index == 3'(slc_pkg::NUM_CLASSES - 1))
      else $error("last flag on wrong class");

   a_prob_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_probability <= 17'd65536)
      else $error("probability above one");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_operation == slc_pkg::OP_START |=> !req_ready)
      else $error("request taken during a run");

   a_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp valid after reset");

endmodule

bind stacked_lda_softmax_classifier slc_checker u_slc_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req.valid),
   .req_ready       (req.ready),
   .req_operation   (req.operation),
   .rsp_valid       (rsp.valid),
   .rsp_ready       (rsp.ready),
   .rsp_class_index (rsp.class_index),
   .rsp_probability (rsp.probability),
   .rsp_last        (rsp.last)
);

[test/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the stacked softmax classifier.
// Every store the classifier reads is filled first. Directed loads and starts
// follow: extreme values, score saturation, a vanished exponential and writes
// beyond the stores. Random loads and starts come last. A bit-accurate model
// predicts the eight class probabilities of every start. Each result is
// compared against the oldest prediction while both channels stall at random.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NCLS       = slc_pkg::NUM_CLASSES;
   localparam int META_BASE  = slc_pkg::NUM_CLASSES
                               * (slc_pkg::TD_LEN + slc_pkg::FD_LEN + slc_pkg::CROSS_FEATURES);
   localparam int WGT_USED   = META_BASE + slc_pkg::NUM_CLASSES * slc_pkg::META_LEN;
   localparam int CYCLE_CAP  = 2000000;

   typedef struct {
      logic [2:0]  class_index;
      logic [16:0] probability;
      logic        last;
   } class_result_type;

   class class_prob_scoreboard;
      logic signed [31:0] features   [slc_pkg::NUM_FEATURES];
      logic signed [31:0] weights    [slc_pkg::WEIGHT_DEPTH];
      logic signed [31:0] intercepts [slc_pkg::ICPT_DEPTH];
      logic [16:0]        spec_probs [slc_pkg::META_LEN];
      class_result_type   expected_q [$];
      int                 mismatches;

      function new();
         mismatches = 0;
         foreach (features[i]) features[i] = '0;
         foreach (weights[i]) weights[i] = '0;
         foreach (intercepts[i]) intercepts[i] = '0;
         foreach (spec_probs[i]) spec_probs[i] = '0;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function logic [16:0] exp_neg(longint unsigned d);
         longint unsigned r;
         if (d >= 64'd1 << 20) return '0;
         r = 64'd1 << 32;
         for (int i = 0; i < slc_pkg::EXP_BITS; i++)
            if (d[i]) r = (r * 64'(slc_pkg::EXP_TABLE[i]) + 64'h8000_0000) >> 32;
         return 17'((r + 64'h8000) >> 16);
      endfunction

      // linear scores, max-subtracted softmax, rounded exact division
      function void score_stage(int stage, int base, longint vec [36], int len,
                                output logic [16:0] probs [NCLS]);
         longint          score [NCLS];
         logic [16:0]     e [NCLS];
         longint          best;
         longint          acc;
         longint unsigned sum;
         sum = 0;
         for (int c = 0; c < NCLS; c++) begin
            acc = longint'(intercepts[stage * NCLS + c]);
            for (int j = 0; j < len; j++)
               acc += (vec[j] * longint'(weights[(base + c * len + j)
                                                 % slc_pkg::WEIGHT_DEPTH])) >>> 16;
            if (acc > 64'sd2147483647) acc = 64'sd2147483647;
            if (acc < -64'sd2147483648) acc = -64'sd2147483648;
            score[c] = acc;
         end
         best = score[0];
         for (int c = 1; c < NCLS; c++)
            if (score[c] > best) best = score[c];
         for (int c = 0; c < NCLS; c++) begin
            e[c] = exp_neg(longint'(best - score[c]));
            sum += e[c];
         end
         for (int c = 0; c < NCLS; c++)
            probs[c] = 17'((64'(e[c]) * 65536 + sum / 2) / sum);
      endfunction

      function void note_request(slc_pkg::op_type op, logic [9:0] addr,
                                 logic signed [31:0] val);
         longint           vec [36];
         logic [16:0]      probs [NCLS];
         class_result_type res;
         case (op)
            slc_pkg::OP_WRITE_FEATURE:
               if (addr < slc_pkg::NUM_FEATURES) features[addr] = val;
            slc_pkg::OP_WRITE_WEIGHT:
               if (addr < slc_pkg::WEIGHT_DEPTH) weights[addr] = val;
            slc_pkg::OP_WRITE_INTERCEPT:
               if (addr < slc_pkg::ICPT_DEPTH) intercepts[addr] = val;
            slc_pkg::OP_START: begin
               foreach (vec[j]) vec[j] = 0;
               for (int j = 0; j < slc_pkg::TD_LEN; j++)
                  vec[j] = features[(j / slc_pkg::TD_PER_CH) * slc_pkg::PER_CHANNEL_FEATURES
                                    + j % slc_pkg::TD_PER_CH];
               score_stage(0, 0, vec, slc_pkg::TD_LEN, probs);
               for (int c = 0; c < NCLS; c++) spec_probs[c] = probs[c];
               for (int j = 0; j < slc_pkg::FD_LEN; j++)
                  vec[j] = features[(j / slc_pkg::FD_PER_CH) * slc_pkg::PER_CHANNEL_FEATURES
                                    + slc_pkg::TD_PER_CH + j % slc_pkg::FD_PER_CH];
               score_stage(1, NCLS * slc_pkg::TD_LEN, vec, slc_pkg::FD_LEN, probs);
               for (int c = 0; c < NCLS; c++) spec_probs[NCLS + c] = probs[c];
               for (int j = 0; j < slc_pkg::CROSS_FEATURES; j++)
                  vec[j] = features[slc_pkg::CC_OFFSET + j];
               score_stage(2, NCLS * (slc_pkg::TD_LEN + slc_pkg::FD_LEN), vec,
                           slc_pkg::CROSS_FEATURES, probs);
               for (int c = 0; c < NCLS; c++)
                  spec_probs[2 * NCLS + c] = probs[c];
               for (int j = 0; j < slc_pkg::META_LEN; j++) vec[j] = longint'(spec_probs[j]);
               score_stage(3, META_BASE, vec, slc_pkg::META_LEN, probs);
               for (int c = 0; c < NCLS; c++) begin
                  res.class_index = 3'(c);
                  res.probability = probs[c];
                  res.last        = (c == NCLS - 1);
                  expected_q.push_back(res);
               end
            end
         endcase
      endfunction

      function void check_result(class_result_type got);
         class_result_type want;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: class %0d prob %0d last %0d",
                        got.class_index, got.probability, got.last);
            return;
         end
         want = expected_q.pop_front();
         if (got.class_index !== want.class_index || got.probability !== want.probability
             || got.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
               $display("result differs: expected class %0d prob %0d last %0d, got %0d %0d %0d",
                        want.class_index, want.probability, want.last,
                        got.class_index, got.probability, got.last);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   slc_req_if req_ch();
   slc_rsp_if rsp_ch();
   class_prob_scoreboard sb = new();
   int send_idle_pct;
   int recv_idle_pct;
   int hold_cycles = 0;
   logic hold_request = 1'b0;
   logic hold_started = 1'b0;
   int cycle_count = 0;

   stacked_lda_softmax_classifier dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_CAP) begin
         $display("stacked_lda_softmax_classifier: mismatch");
         $finish;
      end
   end

   // receiver: long hold when asked, random stalls otherwise
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_request && !hold_started) begin
         rsp_ch.ready <= 1'b0;
         hold_cycles  <= 12000;
         hold_started <= 1'b1;
      end else if (hold_cycles > 0) begin
         rsp_ch.ready <= 1'b0;
         hold_cycles  <= hold_cycles - 1;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      class_result_type got;
      if (!reset && req_ch.valid && req_ch.ready)
         sb.note_request(slc_pkg::op_type'(req_ch.operation), req_ch.address, req_ch.value);
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.class_index = rsp_ch.class_index;
         got.probability = rsp_ch.probability;
         got.last        = rsp_ch.last;
         sb.check_result(got);
      end
   end

   function automatic logic [31:0] pick_value();
      case ($urandom_range(9))
         0:       return $urandom();
         1:       return 32'h7FFF_FFFF;
         2:       return 32'h8000_0000;
         3:       return '0;
         default: return 32'($signed($urandom_range(262143)) - 131072);
      endcase
   endfunction

   // present one transaction, idling at random first; returns once accepted
   task automatic send_req(slc_pkg::op_type op, logic [9:0] addr, logic [31:0] val);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.operation <= op;
      req_ch.address   <= addr;
      req_ch.value     <= val;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   task automatic send_random_req();
      case ($urandom_range(99)) inside
         [0:11]:  send_req(slc_pkg::OP_START, 10'($urandom()), $urandom());
         [12:41]: send_req(slc_pkg::OP_WRITE_FEATURE, ($urandom_range(9) == 0) ?
                           10'($urandom()) : 10'($urandom_range(slc_pkg::NUM_FEATURES - 1)),
                           pick_value());
         [42:81]: send_req(slc_pkg::OP_WRITE_WEIGHT, ($urandom_range(9) == 0) ?
                           10'($urandom()) : 10'($urandom_range(WGT_USED - 1)), pick_value());
         default: send_req(slc_pkg::OP_WRITE_INTERCEPT, ($urandom_range(9) == 0) ?
                           10'($urandom()) : 10'($urandom_range(slc_pkg::ICPT_DEPTH - 1)),
                           pick_value());
      endcase
   endtask

   initial begin
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.operation = slc_pkg::OP_WRITE_FEATURE;
      req_ch.address   = '0;
      req_ch.value     = '0;
      send_idle_pct    = 9;
      recv_idle_pct    = 54;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // fill every entry that a start reads, with moderate values
      for (int i = 0; i < slc_pkg::NUM_FEATURES; i++)
         send_req(slc_pkg::OP_WRITE_FEATURE, 10'(i),
                  32'($signed($urandom_range(131071)) - 65536));
      for (int i = 0; i < WGT_USED; i++)
         send_req(slc_pkg::OP_WRITE_WEIGHT, 10'(i),
                  32'($signed($urandom_range(65535)) - 32768));
      for (int i = 0; i < slc_pkg::ICPT_DEPTH; i++)
         send_req(slc_pkg::OP_WRITE_INTERCEPT, 10'(i),
                  32'($signed($urandom_range(131071)) - 65536));
      send_req(slc_pkg::OP_START, '0, '0);

      // saturate the first time-domain score upward, vanish the others
      send_req(slc_pkg::OP_WRITE_FEATURE, 10'd0, 32'h7FFF_FFFF);
      send_req(slc_pkg::OP_WRITE_WEIGHT, 10'd0, 32'h7FFF_FFFF);
      send_req(slc_pkg::OP_WRITE_INTERCEPT, 10'd0, 32'h7FFF_FFFF);
      send_req(slc_pkg::OP_START, 10'h3FF, 32'hFFFF_FFFF);
      // drive it to the negative limit
      send_req(slc_pkg::OP_WRITE_WEIGHT, 10'd0, 32'h8000_0000);
      send_req(slc_pkg::OP_WRITE_INTERCEPT, 10'd0, 32'h8000_0000);
      send_req(slc_pkg::OP_WRITE_INTERCEPT, 10'd31, 32'h7FFF_FFFF);
      send_req(slc_pkg::OP_START, '0, '0);
      // writes beyond the stores are dropped; top weight word is never read
      send_req(slc_pkg::OP_WRITE_FEATURE, 10'(slc_pkg::NUM_FEATURES), 32'h7FFF_FFFF);
      send_req(slc_pkg::OP_WRITE_FEATURE, 10'h3FF, 32'h8000_0000);
      send_req(slc_pkg::OP_WRITE_INTERCEPT, 10'(slc_pkg::ICPT_DEPTH), 32'h7FFF_FFFF);
      send_req(slc_pkg::OP_WRITE_INTERCEPT, 10'h3FF, 32'h8000_0000);
      send_req(slc_pkg::OP_WRITE_WEIGHT, 10'h3FF, 32'hFFFF_FFFF);
      send_req(slc_pkg::OP_WRITE_FEATURE, 10'(slc_pkg::NUM_FEATURES - 1), 32'h8000_0000);
      send_req(slc_pkg::OP_START, 10'h2AA, 32'h5555_5555);
      send_req(slc_pkg::OP_START, 10'h155, 32'hAAAA_AAAA);

      for (int i = 0; i < 105; i++) send_random_req();
      send_idle_pct = 54;
      recv_idle_pct = 9;
      for (int i = 0; i < 105; i++) send_random_req();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      // hold the receiver long enough for the block to fill and stall its input
      hold_request <= 1'b1;
      for (int i = 0; i < 100; i++) send_random_req();
      req_ch.valid <= 1'b0;

      while (sb.pending() > 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("stacked_lda_softmax_classifier: match");
      else
         $display("stacked_lda_softmax_classifier: mismatch");
      $finish;
   end

endmodule

[sim.f]
sv/slc_pkg.sv
sv/slc_req_if.sv
sv/stacked_lda_softmax_classifier.sv
sv/slc_checker.sv
test/testbench.sv
